FILE: src/isr_pkg.sv
package isr_pkg;

	// Fixed field widths of the request and result ports
	localparam int RADICAND_W = 32;
	localparam int ROOT_W     = 16;

endpackage

FILE: src/integer_square_root_unit.sv
// Floor square root of an unsigned 32-bit radicand, returned as a 16-bit root,
// computed with the binary digit-by-digit (restoring) method. The radicand is
// masked to VALUE_WIDTH bits (zero-extended when VALUE_WIDTH is above 32); the
// root port carries the low 16 bits of the root. Each of the (VALUE_WIDTH+1)/2
// pipeline stages (16 at the default width) resolves one root bit with one
// trial compare and subtract. A request is loaded into the first stage at its
// accepting edge, and its root passes through the stage registers in order.
// A new request can enter every cycle while radicand_stall is low.
// The last stage is the output register. Stall on the result side holds only
// the stages that are full; empty stages keep filling, and the request channel
// stalls once the stage at the entry is full and cannot move.
// Nothing is kept between items and there is no configuration.
module integer_square_root_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radicand_valid,
	output logic                         radicand_stall,
	input  logic [isr_pkg::RADICAND_W-1:0] radicand,
	output logic                         root_valid,
	input  logic                         root_stall,
	output logic [isr_pkg::ROOT_W-1:0]   root
);

	import isr_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int STEPS = (VALUE_WIDTH + 1) / 2;
	localparam int TOP   = (VALUE_WIDTH - 1) & ~1;

	// Stage registers: index i is the output of stage i
	logic [W-1:0]   rem_s  [STEPS];
	logic [W-1:0]   root_s [STEPS];
	logic           valid_s [STEPS];
	logic           stage_ready [STEPS];

	logic [W-1:0] rem_in   [STEPS];
	logic [W-1:0] root_in  [STEPS];
	logic [W-1:0] rem_nx   [STEPS];
	logic [W-1:0] root_nx  [STEPS];
	logic         valid_in [STEPS];

	logic [W-1:0] radicand_w;

	// Mask or extend the radicand to the datapath width
	generate
		if (W <= RADICAND_W) begin : g_mask
			assign radicand_w = radicand[W-1:0];
		end else begin : g_ext
			assign radicand_w = {{(W-RADICAND_W){1'b0}}, radicand};
		end
	endgenerate

	genvar i;
	generate
		for (i = 0; i < STEPS; i++) begin : g_stage
			if (i == 0) begin : g_first
				assign valid_in[i] = radicand_valid;
				assign rem_in[i]   = radicand_w;
				assign root_in[i]  = '0;
			end else begin : g_next
				assign valid_in[i] = valid_s[i-1];
				assign rem_in[i]   = rem_s[i-1];
				assign root_in[i]  = root_s[i-1];
			end

			// A stage loads when it is empty or its content moves on
			if (i == STEPS - 1) begin : g_last_rdy
				assign stage_ready[i] = !valid_s[i] || !root_stall;
			end else begin : g_mid_rdy
				assign stage_ready[i] = !valid_s[i] || stage_ready[i+1];
			end

			isr_step #(
				.W   (W),
				.BIT (TOP - 2 * i)
			) u_step (
				.rem_in   (rem_in[i]),
				.root_in  (root_in[i]),
				.rem_out  (rem_nx[i]),
				.root_out (root_nx[i])
			);

			// Advance valid on every load; a stalled stage holds
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[i] <= 1'b0;
				end else if (stage_ready[i]) begin
					valid_s[i] <= valid_in[i];
				end
			end

			// Capture payload only with a valid request
			always_ff @(posedge clk) begin
				if (stage_ready[i] && valid_in[i]) begin
					rem_s[i]  <= rem_nx[i];
					root_s[i] <= root_nx[i];
				end
			end
		end
	endgenerate

	assign radicand_stall = !stage_ready[0];
	assign root_valid     = valid_s[STEPS-1];

	// Drop root bits above the result field, or zero-extend a narrow root
	generate
		if (W >= ROOT_W) begin : g_root_cut
			assign root = root_s[STEPS-1][ROOT_W-1:0];
		end else begin : g_root_ext
			assign root = {{(ROOT_W-W){1'b0}}, root_s[STEPS-1]};
		end
	endgenerate

endmodule

FILE: src/isr_step.sv
module isr_step #(
	parameter int W   = 32,
	parameter int BIT = 30
) (
	input  logic [W-1:0] rem_in,
	input  logic [W-1:0] root_in,
	output logic [W-1:0] rem_out,
	output logic [W-1:0] root_out
);

	localparam logic [W-1:0] TRIAL = {{(W-1){1'b0}}, 1'b1} << BIT;

	logic [W-1:0] cand;
	logic         take;

	// One restoring digit step: subtract the trial value when it fits
	assign cand     = root_in + TRIAL;
	assign take     = (rem_in >= cand);
	assign rem_out  = take ? (rem_in - cand) : rem_in;
	assign root_out = take ? ((root_in >> 1) + TRIAL) : (root_in >> 1);

endmodule
